/* design/i2cms_pkg.sv */
// shared types and constants of the i2c master pin sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_GETACK = 2'd3
  } op_e;

  // one command word
  typedef struct packed {
    op_e        op;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } in_word_t;

  // one pin step word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [1:0] hold_us;
    logic       nack;
    logic       last_step;
  } out_word_t;

  // hold times in microseconds
  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_SHORT = 2'd1;
  localparam logic [1:0] HOLD_LONG  = 2'd2;

  // write byte: one lead step, three steps per bit, one tail step
  localparam int unsigned WRITE_STEPS = 26;
  localparam int unsigned STEP_W      = $clog2(WRITE_STEPS);

  // default depth of the command queue
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

/* design/i2cms_front.sv */
// command intake and queue in front of the pin step sequencer
`timescale 1ns / 1ps

module i2cms_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cms_pkg::in_word_t in_word_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output i2cms_pkg::in_word_t head_o
);
  import i2cms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  in_word_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  in_word_t        clean_word;

  // unused fields are cleared so the queue holds only what the command needs
  always_comb begin
    clean_word = in_word_i;
    if (in_word_i.op != OP_WRITE) begin
      clean_word.tx_byte = '0;
    end
    if (in_word_i.op != OP_GETACK) begin
      clean_word.sda_sample = 1'b0;
    end
  end

  assign in_stall_o   = (cnt_q == FullCnt);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= clean_word;
    end
  end

endmodule

/* design/i2cms_back.sv */
// pin step sequencer: walks the step run of the queued command
`timescale 1ns / 1ps

module i2cms_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  i2cms_pkg::in_word_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cms_pkg::out_word_t out_word_o
);
  import i2cms_pkg::*;

  localparam logic [STEP_W-1:0] WriteTail = STEP_W'(WRITE_STEPS - 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        ph_q, ph_d;
  logic [2:0]        bit_q, bit_d;
  logic              sda_q, sda_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;
  out_word_t         step_w;
  logic              load;
  logic              in_body;
  logic              cur_bit;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign in_body = (step_q != '0) && (step_q != WriteTail);
  assign cur_bit = head_i.tx_byte[3'd7 - bit_q];

  // pin levels of the present step
  always_comb begin
    step_w = '{scl_level: 1'b0, sda_level: sda_q, hold_us: HOLD_NONE,
               nack: 1'b0, last_step: 1'b0};
    case (head_i.op)
      OP_START: begin
        case (step_q)
          STEP_W'(0): step_w = '{1'b1, 1'b1, HOLD_LONG, 1'b0, 1'b0};
          STEP_W'(1): step_w = '{1'b1, 1'b0, HOLD_LONG, 1'b0, 1'b0};
          default:    step_w = '{1'b0, 1'b0, HOLD_NONE, 1'b0, 1'b1};
        endcase
      end
      OP_STOP: begin
        case (step_q)
          STEP_W'(0): step_w = '{1'b0, 1'b0, HOLD_LONG, 1'b0, 1'b0};
          STEP_W'(1): step_w = '{1'b1, 1'b0, HOLD_LONG, 1'b0, 1'b0};
          default:    step_w = '{1'b1, 1'b1, HOLD_LONG, 1'b0, 1'b1};
        endcase
      end
      OP_WRITE: begin
        if (step_q == '0) begin
          step_w = '{1'b0, sda_q, HOLD_LONG, 1'b0, 1'b0};
        end else if (in_body) begin
          step_w = '{(ph_q == 2'd1), cur_bit, HOLD_LONG, 1'b0, 1'b0};
        end else begin
          step_w = '{1'b0, sda_q, HOLD_SHORT, 1'b0, 1'b1};
        end
      end
      OP_GETACK: begin
        case (step_q)
          STEP_W'(0): step_w = '{1'b0, sda_q, HOLD_SHORT, 1'b0, 1'b0};
          STEP_W'(1): step_w = '{1'b0, 1'b1, HOLD_SHORT, 1'b0, 1'b0};
          // no ack leaves scl high and ends the run here
          STEP_W'(2): step_w = '{1'b1, 1'b1, HOLD_SHORT, head_i.sda_sample,
                                 head_i.sda_sample};
          default:    step_w = '{1'b0, 1'b1, HOLD_SHORT, 1'b0, 1'b1};
        endcase
      end
      default: begin
        step_w = '{1'b0, sda_q, HOLD_NONE, 1'b0, 1'b1};
      end
    endcase
  end

  assign pop_o = load && step_w.last_step;

  // step counters, line level and output register
  always_comb begin
    step_d      = step_q;
    ph_d        = ph_q;
    bit_d       = bit_q;
    sda_d       = sda_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_d       = step_w;
      out_valid_d = 1'b1;
      sda_d       = step_w.sda_level;
      if (step_w.last_step) begin
        step_d = '0;
        ph_d   = '0;
        bit_d  = '0;
      end else begin
        step_d = step_q + 1'b1;
        if ((head_i.op == OP_WRITE) && in_body) begin
          if (ph_q == 2'd2) begin
            ph_d  = '0;
            bit_d = bit_q + 1'b1;
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      ph_q        <= '0;
      bit_q       <= '0;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      ph_q        <= ph_d;
      bit_q       <= bit_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* design/i2cms_top_placeholder_unused.sv */
// registered range check of the hold code on the step channel
`timescale 1ns / 1ps

module i2cms_hold_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] hold_i,
  output logic       bad_o
);
  logic bad_q;

  // flag a hold code outside the defined range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else begin
      bad_q <= (hold_i == 2'd3);
    end
  end

  assign bad_o = bad_q;

endmodule

/* design/i2c_master_pin_sequencer_core.sv */
// top level of the write-only i2c master pin sequencer
`timescale 1ns / 1ps

// Write-only i2c master that turns each command word into a run of pin steps.
// in channel: in_valid_i / in_stall_o carry one command word (op, tx_byte,
// sda_sample). out channel: out_valid_o / out_stall_i carry one pin step word
// (scl_level, sda_level, hold_us, nack, last_step); last_step closes a run.
// A command word enters a small queue; the sequencer behind it sends one
// step per cycle into the output register unless out_stall_i holds a step,
// and registers the first step of a command once it reaches the queue head.
// The step sequencer sets the pace, one step word per cycle unless stalled:
// start and stop runs have 3 steps, get ack 3 or 4, write byte 26.
// Commands queue while a run is under way; in_stall_o rises when the queue
// is full. When out_stall_i is high on a valid step word, the word holds and
// the sequencer waits; the queue still takes words until full.
// Reset empties the queue and output register and sets the tracked data line
// level to released high.
module i2c_master_pin_sequencer_core #(
  parameter int unsigned QueueDepth = i2cms_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cms_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cms_pkg::out_word_t out_word_o
);
  import i2cms_pkg::*;

  logic     head_valid;
  logic     pop;
  in_word_t head;
  logic     hold_bad;

  // command queue
  i2cms_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // step sequencer
  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // registered range check on the sent hold code
  i2cms_hold_check u_hold_check (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hold_i(out_valid_o ? out_word_o.hold_us : HOLD_NONE),
    .bad_o (hold_bad)
  );

`ifndef ASSERT_OFF
  // a run only ends on a command that is in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("step run ended with empty queue");

  // a missing ack always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.nack) |-> out_word_o.last_step)
    else $error("nack on a step that is not last");

  // hold codes stay inside the defined range
  assert property (@(posedge clk_i) disable iff (!rst_ni) !hold_bad)
    else $error("hold code out of range");

  // a full queue is only reached while the sequencer has a head to work on
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> head_valid)
    else $error("queue full without a head word");
`endif

endmodule

/* bench/i2cms_checker.sv */
// pin step checker: predicts the step words of each command word and compares
`timescale 1ns / 1ps

module i2cms_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  i2cms_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  i2cms_pkg::out_word_t out_word_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          steps_checked_o
);
  import i2cms_pkg::*;

  // present data line level as the predictor sees it
  logic        sda_line = 1'b1;
  out_word_t   step_queue[$];
  int unsigned fail_count = 0;
  int unsigned steps_checked = 0;

  // print the first few, count them all
  task automatic report_mismatch(input string what);
    if (fail_count < 20) $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  // one predicted step word, data line level follows it
  function automatic void add_step(input logic scl, input logic sda,
                                   input logic [1:0] hold, input logic nack,
                                   input logic last);
    out_word_t s;
    sda_line    = sda;
    s.scl_level = scl;
    s.sda_level = sda;
    s.hold_us   = hold;
    s.nack      = nack;
    s.last_step = last;
    step_queue.push_back(s);
  endfunction

  // full run of step words for one command word
  function automatic void push_pin_steps(input in_word_t w);
    case (w.op)
      OP_START: begin
        add_step(1'b1, 1'b1, HOLD_LONG, 1'b0, 1'b0);
        add_step(1'b1, 1'b0, HOLD_LONG, 1'b0, 1'b0);
        add_step(1'b0, 1'b0, HOLD_NONE, 1'b0, 1'b1);
      end
      OP_STOP: begin
        add_step(1'b0, 1'b0, HOLD_LONG, 1'b0, 1'b0);
        add_step(1'b1, 1'b0, HOLD_LONG, 1'b0, 1'b0);
        add_step(1'b1, 1'b1, HOLD_LONG, 1'b0, 1'b1);
      end
      OP_WRITE: begin
        add_step(1'b0, sda_line, HOLD_LONG, 1'b0, 1'b0);
        // msb first, low-high-low clock per bit
        for (int i = 7; i >= 0; i--) begin
          add_step(1'b0, w.tx_byte[i], HOLD_LONG, 1'b0, 1'b0);
          add_step(1'b1, w.tx_byte[i], HOLD_LONG, 1'b0, 1'b0);
          add_step(1'b0, w.tx_byte[i], HOLD_LONG, 1'b0, 1'b0);
        end
        add_step(1'b0, sda_line, HOLD_SHORT, 1'b0, 1'b1);
      end
      default: begin
        add_step(1'b0, sda_line, HOLD_SHORT, 1'b0, 1'b0);
        add_step(1'b0, 1'b1, HOLD_SHORT, 1'b0, 1'b0);
        // no ack leaves scl high and ends the run
        if (w.sda_sample) begin
          add_step(1'b1, 1'b1, HOLD_SHORT, 1'b1, 1'b1);
        end else begin
          add_step(1'b1, 1'b1, HOLD_SHORT, 1'b0, 1'b0);
          add_step(1'b0, 1'b1, HOLD_SHORT, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  // compare one step word against the oldest prediction
  task automatic check_step(input out_word_t got);
    out_word_t want;
    if (step_queue.size() == 0) begin
      report_mismatch($sformatf("step word %b arrived with none predicted", got));
      return;
    end
    want = step_queue.pop_front();
    if (got.scl_level !== want.scl_level)
      report_mismatch($sformatf("step %0d scl_level got %b want %b",
                                steps_checked, got.scl_level, want.scl_level));
    if (got.sda_level !== want.sda_level)
      report_mismatch($sformatf("step %0d sda_level got %b want %b",
                                steps_checked, got.sda_level, want.sda_level));
    if (got.hold_us !== want.hold_us)
      report_mismatch($sformatf("step %0d hold_us got %0d want %0d",
                                steps_checked, got.hold_us, want.hold_us));
    if (got.nack !== want.nack)
      report_mismatch($sformatf("step %0d nack got %b want %b",
                                steps_checked, got.nack, want.nack));
    if (got.last_step !== want.last_step)
      report_mismatch($sformatf("step %0d last_step got %b want %b",
                                steps_checked, got.last_step, want.last_step));
    steps_checked++;
  endtask

  // watch both channels at each edge, outputs first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sda_line = 1'b1;
      step_queue.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_step(out_word_i);
      if (in_valid_i && !in_stall_i) push_pin_steps(in_word_i);
      pending_o <= step_queue.size();
    end
    fail_count_o    <= fail_count;
    steps_checked_o <= steps_checked;
  end

endmodule

/* bench/tb_top.sv */
// testbench top of the i2c master pin sequencer: stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import i2cms_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cmd_valid;
  logic        cmd_stall;
  in_word_t    cmd_word;
  logic        step_valid;
  logic        step_stall = 1'b0;
  out_word_t   step_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned steps_checked;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned op_count[4] = '{0, 0, 0, 0};

  i2c_master_pin_sequencer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_word_i   (cmd_word),
    .out_valid_o (step_valid),
    .out_stall_i (step_stall),
    .out_word_o  (step_word)
  );

  i2cms_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (cmd_valid),
    .in_stall_i      (cmd_stall),
    .in_word_i       (cmd_word),
    .out_valid_i     (step_valid),
    .out_stall_i     (step_stall),
    .out_word_i      (step_word),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .steps_checked_o (steps_checked)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // random receiver stall
  always @(posedge clk) begin
    step_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // offer one command word, with random idle cycles ahead of it
  task automatic send_cmd(input op_e op, input logic [7:0] data, input logic sample);
    in_word_t w;
    w.op         = op;
    w.tx_byte    = data;
    w.sda_sample = sample;
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    op_count[op]++;
  endtask

  // hold off until every predicted step word has come
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // well-formed transfer: start, bytes each with ack read, usually a stop
  task automatic send_transfer(output int unsigned sent);
    int unsigned n_bytes;
    n_bytes = $urandom_range(1, 4);
    send_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (n_bytes) begin
      send_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_cmd(OP_GETACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    sent = 2 * n_bytes + 1;
    // now and then a repeated start instead of a stop
    if ($urandom_range(7) != 0) begin
      send_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
      sent++;
    end
  endtask

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned n;
    rst_n     = 1'b0;
    cmd_valid = 1'b0;
    cmd_word  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: odd orders, unused inputs, byte extremes, ack and no ack
    send_cmd(OP_STOP,   8'h00, 1'b0);
    send_cmd(OP_GETACK, 8'h00, 1'b1);
    send_cmd(OP_WRITE,  8'h00, 1'b0);
    send_cmd(OP_GETACK, 8'h00, 1'b0);
    send_cmd(OP_START,  8'hFF, 1'b1);
    send_cmd(OP_START,  8'h00, 1'b0);
    send_cmd(OP_WRITE,  8'hFF, 1'b1);
    send_cmd(OP_GETACK, 8'hFF, 1'b0);
    send_cmd(OP_WRITE,  8'hA5, 1'b0);
    send_cmd(OP_GETACK, 8'h5A, 1'b1);
    send_cmd(OP_WRITE,  8'h5A, 1'b1);
    send_cmd(OP_STOP,   8'hFF, 1'b1);
    send_cmd(OP_STOP,   8'h00, 1'b0);
    send_cmd(OP_WRITE,  8'h01, 1'b0);
    send_cmd(OP_WRITE,  8'h80, 1'b1);
    send_cmd(OP_GETACK, 8'h00, 1'b0);
    send_cmd(OP_GETACK, 8'hFF, 1'b1);
    send_cmd(OP_START,  8'h00, 1'b0);
    send_cmd(OP_STOP,   8'h00, 1'b0);
    wait_drained();

    // random: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(3) == 0) begin
          // noise command in any order
          send_cmd(op_e'($urandom_range(3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
          sent++;
        end else begin
          send_transfer(n);
          sent += n;
        end
      end
      wait_drained();
    end

    // let any stray step word show up
    stall_pct = 0;
    repeat (30) @(posedge clk);
    $display("sent %0d start, %0d stop, %0d write and %0d get ack words",
             op_count[OP_START], op_count[OP_STOP], op_count[OP_WRITE],
             op_count[OP_GETACK]);
    $display("%0d pin step words checked across four idle and stall mixes",
             steps_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d step words outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
